@@ hw/rtl/ple_pkg.sv @@
// Package for the positional list engine: item types, command codes,
// microcode word layout and the microcode program itself.
// Used by every module under hw/rtl but ple_store.
package ple_pkg;

   // Command codes of the req_item.cmd field
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_INSERT_AT  = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_POP_BACK   = 3'd4;
   localparam logic [2:0] CMD_REMOVE_AT  = 3'd5;
   localparam logic [2:0] CMD_SEARCH     = 3'd6;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [6:0] count;
   } rsp_type;

   // Microcode program steps
   typedef enum logic [3:0] {
      ST_INS_TEST = 4'd0,
      ST_INS_RD   = 4'd1,
      ST_INS_WR   = 4'd2,
      ST_INS_PUT  = 4'd3,
      ST_REM_TEST = 4'd4,
      ST_REM_RD   = 4'd5,
      ST_REM_WR   = 4'd6,
      ST_REM_FIN  = 4'd7,
      ST_SR_TEST  = 4'd8,
      ST_SR_RD    = 4'd9,
      ST_SR_CMP   = 4'd10,
      ST_SR_HIT   = 4'd11,
      ST_FAIL     = 4'd12
   } step_type;

   typedef enum logic [1:0] {
      ADDR_PTR = 2'd0,
      ADDR_DEC = 2'd1,
      ADDR_INC = 2'd2
   } addr_sel_type;

   typedef enum logic {
      WD_RDATA = 1'b0,
      WD_VALUE = 1'b1
   } wdata_sel_type;

   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_INC  = 2'd1,
      OP_DEC  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      JMP_NONE     = 2'd0,
      JMP_ALWAYS   = 2'd1,
      JMP_EQ_LIM   = 2'd2,
      JMP_NO_MATCH = 2'd3
   } jump_type;

   // One control word; all zero means no operation
   typedef struct packed {
      logic          rd_en;
      logic          wr_en;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      op_type        ptr_op;
      op_type        cnt_op;
      jump_type      jump;
      step_type      target;
      logic          set_ok;
      logic          done;
   } ucode_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic     eq_lim;
      logic     match;
      step_type entry;
   } status_type;

   // Microcode ROM
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      w = '0;
      case (step)
         ST_INS_TEST: begin
            w.jump   = JMP_EQ_LIM;
            w.target = ST_INS_PUT;
         end
         ST_INS_RD: begin
            w.rd_en    = 1'b1;
            w.addr_sel = ADDR_DEC;
         end
         ST_INS_WR: begin
            w.wr_en     = 1'b1;
            w.addr_sel  = ADDR_PTR;
            w.wdata_sel = WD_RDATA;
            w.ptr_op    = OP_DEC;
            w.jump      = JMP_ALWAYS;
            w.target    = ST_INS_TEST;
         end
         ST_INS_PUT: begin
            w.wr_en     = 1'b1;
            w.addr_sel  = ADDR_PTR;
            w.wdata_sel = WD_VALUE;
            w.cnt_op    = OP_INC;
            w.set_ok    = 1'b1;
            w.done      = 1'b1;
         end
         ST_REM_TEST: begin
            w.jump   = JMP_EQ_LIM;
            w.target = ST_REM_FIN;
         end
         ST_REM_RD: begin
            w.rd_en    = 1'b1;
            w.addr_sel = ADDR_INC;
         end
         ST_REM_WR: begin
            w.wr_en     = 1'b1;
            w.addr_sel  = ADDR_PTR;
            w.wdata_sel = WD_RDATA;
            w.ptr_op    = OP_INC;
            w.jump      = JMP_ALWAYS;
            w.target    = ST_REM_TEST;
         end
         ST_REM_FIN: begin
            w.cnt_op = OP_DEC;
            w.set_ok = 1'b1;
            w.done   = 1'b1;
         end
         ST_SR_TEST: begin
            w.jump   = JMP_EQ_LIM;
            w.target = ST_FAIL;
         end
         ST_SR_RD: begin
            w.rd_en    = 1'b1;
            w.addr_sel = ADDR_PTR;
         end
         ST_SR_CMP: begin
            w.ptr_op = OP_INC;
            w.jump   = JMP_NO_MATCH;
            w.target = ST_SR_TEST;
         end
         ST_SR_HIT: begin
            w.set_ok = 1'b1;
            w.done   = 1'b1;
         end
         ST_FAIL: begin
            w.done = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/positional_list_engine.sv @@
// Positional list engine: an ordered list of up to DEPTH signed 32-bit
// values with insert, remove and search commands at the ends or a position.
// Depends on ple_pkg, ple_sequencer and ple_datapath.
//
// Usage:
//   Drive req_item and raise start; the item is taken at a clock edge where
//   start is high and busy is low. busy stays high while the microcode walks
//   the store. One result comes back on rsp_item with rsp_strobe high for a
//   single cycle: ok and the count after the command.
// Shifting costs three steps per slot (test, read, write) since the store
//   has one registered read port and one write port; the next item can be
//   taken in the cycle the strobe is high.
// Reset clears the count, the sequencer and the strobe; the store is not
//   cleared, since only slots below the count are ever read.
// The receiver cannot stall: each result must be taken as it is strobed.
module positional_list_engine #(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ple_pkg::req_type    req_item,
   output logic                rsp_strobe,
   output ple_pkg::rsp_type    rsp_item
);
   import ple_pkg::*;

   ucode_type  ctrl;
   status_type status;
   logic       accept;

   assign accept = start && !busy;

   ple_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   ple_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_item),
      .ctrl   (ctrl),
      .status (status),
      .rsp    (rsp_item)
   );
endmodule

@@ hw/rtl/ple_store.sv @@
// Value store of the positional list engine: one write port and one
// registered read port. Depends on nothing.
module ple_store #(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [31:0]                wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [31:0]                rd_data
);
   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // Write slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read slot into the registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/ple_datapath.sv @@
// Datapath of the positional list engine: pointer, limit, count, value
// and flag registers, command dispatch and the value store.
// Depends on ple_pkg and ple_store.
module ple_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  ple_pkg::req_type       req,
   input  ple_pkg::ucode_type     ctrl,
   output ple_pkg::status_type    status,
   output ple_pkg::rsp_type       rsp
);
   import ple_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 7) ? CW : 7;

   logic [CW-1:0]   ptr_ff, ptr_in;
   logic [CW-1:0]   lim_ff, lim_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [31:0]     value_ff;
   logic            ok_ff;

   logic [CMPW-1:0] cnt_w, pos_w, depth_w, cnt_m1, ins_pos, rem_pos;
   logic [CMPW-1:0] ptr_load, lim_load;
   step_type        entry;
   logic [CW-1:0]   addr_full;
   logic [31:0]     wr_data;
   logic [31:0]     rd_data;

   // Decide where the program starts and what the walk covers
   always_comb begin
      cnt_w   = CMPW'(cnt_ff);
      pos_w   = CMPW'(req.position);
      depth_w = CMPW'(DEPTH);
      cnt_m1  = cnt_w - CMPW'(1);
      ins_pos = (req.cmd == CMD_PUSH_FRONT) ? '0 :
                (req.cmd == CMD_PUSH_BACK)  ? cnt_w : pos_w;
      rem_pos = (req.cmd == CMD_POP_FRONT)  ? '0 :
                (req.cmd == CMD_POP_BACK)   ? cnt_m1 : pos_w;
      ptr_load = '0;
      lim_load = cnt_w;
      entry    = ST_FAIL;
      case (req.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
            ptr_load = cnt_w;
            lim_load = ins_pos;
            if (cnt_w != depth_w && ins_pos <= cnt_w) begin
               entry = ST_INS_TEST;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT: begin
            ptr_load = rem_pos;
            lim_load = cnt_m1;
            if (cnt_w != '0 && rem_pos < cnt_w) begin
               entry = ST_REM_TEST;
            end
         end
         CMD_SEARCH: begin
            ptr_load = '0;
            lim_load = cnt_w;
            entry    = ST_SR_TEST;
         end
         default: begin
            entry = ST_FAIL;
         end
      endcase
   end

   // Next pointer, limit and count
   always_comb begin
      ptr_in = ptr_ff;
      lim_in = lim_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         ptr_in = ptr_load[CW-1:0];
         lim_in = lim_load[CW-1:0];
      end else begin
         case (ctrl.ptr_op)
            OP_INC:  ptr_in = ptr_ff + CW'(1);
            OP_DEC:  ptr_in = ptr_ff - CW'(1);
            default: ptr_in = ptr_ff;
         endcase
      end
      case (ctrl.cnt_op)
         OP_INC:  cnt_in = cnt_ff + CW'(1);
         OP_DEC:  cnt_in = cnt_ff - CW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   // Count and flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ok_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (ctrl.done) begin
            ok_ff <= ctrl.set_ok;
         end
      end
   end

   // Walk registers and latched value
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      lim_ff <= lim_in;
      if (accept) begin
         value_ff <= req.value;
      end
   end

   // Store address and write data
   always_comb begin
      case (ctrl.addr_sel)
         ADDR_DEC: addr_full = ptr_ff - CW'(1);
         ADDR_INC: addr_full = ptr_ff + CW'(1);
         default:  addr_full = ptr_ff;
      endcase
      wr_data = (ctrl.wdata_sel == WD_VALUE) ? value_ff : rd_data;
   end

   ple_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (addr_full[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (addr_full[AW-1:0]),
      .rd_data (rd_data)
   );

   assign status.eq_lim = (ptr_ff == lim_ff);
   assign status.match  = (rd_data == value_ff);
   assign status.entry  = entry;

   assign rsp.ok    = ok_ff;
   assign rsp.count = cnt_w[6:0];
endmodule

@@ hw/rtl/ple_sequencer.sv @@
// Microcode sequencer of the positional list engine: step counter,
// busy flag, control word fetch and the result strobe. Depends on ple_pkg.
module ple_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  ple_pkg::status_type    status,
   output ple_pkg::ucode_type     ctrl,
   output logic                   busy,
   output logic                   strobe
);
   import ple_pkg::*;

   step_type pc_ff, pc_in;
   logic     busy_ff, busy_in;
   logic     strobe_ff, strobe_in;
   logic     take;

   // Fetch control word and pick the next step
   always_comb begin
      ctrl = busy_ff ? ucode_rom(pc_ff) : '0;
      case (ctrl.jump)
         JMP_ALWAYS:   take = 1'b1;
         JMP_EQ_LIM:   take = status.eq_lim;
         JMP_NO_MATCH: take = !status.match;
         default:      take = 1'b0;
      endcase
      pc_in     = pc_ff;
      busy_in   = busy_ff;
      strobe_in = busy_ff && ctrl.done;
      if (accept) begin
         pc_in   = status.entry;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ctrl.done) begin
            busy_in = 1'b0;
         end else if (take) begin
            pc_in = ctrl.target;
         end else begin
            pc_in = step_type'(pc_ff + 4'd1);
         end
      end
   end

   // Hold step counter and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= ST_FAIL;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         pc_ff     <= pc_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy   = busy_ff;
   assign strobe = strobe_ff;
endmodule

@@ hw/rtl/ple_checker.sv @@
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine.
module ple_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_strobe,
   input ple_pkg::rsp_type    rsp_item
);

   // An accepted item makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // Busy ends only with a result
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   // A result only follows work
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_strobe |-> $past(busy) && !busy)
      else $error("result without an item in work");

   // Result strobes never come back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   // Hold the result lines steady between results
   a_quiet_between: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !rsp_strobe |-> $stable(rsp_item))
      else $error("result lines moved without a strobe");
endmodule

bind positional_list_engine ple_checker u_ple_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

@@ bench/list_tracker_pkg.sv @@
`timescale 1ns / 100ps
// Answer tracker for the positional list engine bench: a shadow of the stored
// list, the queue of answers still owed by the block, and the answer check.
// Depends on ple_pkg for the item types and command codes.
package list_tracker_pkg;
   import ple_pkg::*;

   localparam int LIST_DEPTH   = 64;
   localparam int REPORT_LIMIT = 10;

   class list_tracker;
      logic signed [31:0] stored[$];
      rsp_type            pending_answers[$];
      int                 answers_checked;
      int                 mismatches;
      int                 stray_answers;
      int                 reported;
      int                 peak_fill;
      int                 full_refusals;
      int                 search_hits;

      // Insert one value ahead of slot pos; refuse on a full list or a gap
      function bit put_at(int pos, logic signed [31:0] v);
         if (stored.size() >= LIST_DEPTH) begin
            full_refusals++;
            return 1'b0;
         end
         if (pos > stored.size())
            return 1'b0;
         stored.insert(pos, v);
         if (stored.size() > peak_fill)
            peak_fill = stored.size();
         return 1'b1;
      endfunction

      // Drop the value at slot pos if it exists
      function bit take_at(int pos);
         if (pos >= stored.size())
            return 1'b0;
         stored.delete(pos);
         return 1'b1;
      endfunction

      // Work out the answer one accepted command owes and queue it
      function void note_command(req_type item);
         rsp_type answer;
         bit      ok;
         int      n;
         n  = stored.size();
         ok = 1'b0;
         case (item.cmd)
            CMD_PUSH_FRONT: ok = put_at(0, item.value);
            CMD_PUSH_BACK:  ok = put_at(n, item.value);
            CMD_INSERT_AT:  ok = put_at(int'(item.position), item.value);
            CMD_POP_FRONT:  ok = take_at(0);
            CMD_POP_BACK: begin
               if (n != 0)
                  ok = take_at(n - 1);
            end
            CMD_REMOVE_AT:  ok = take_at(int'(item.position));
            CMD_SEARCH: begin
               foreach (stored[i])
                  if (stored[i] == item.value)
                     ok = 1'b1;
               if (ok)
                  search_hits++;
            end
            default:        ok = 1'b0;
         endcase
         answer.ok    = ok;
         answer.count = 7'(stored.size());
         pending_answers.push_back(answer);
      endfunction

      // Compare one strobed answer with the oldest one owed
      function void check_answer(rsp_type got);
         rsp_type want;
         if (pending_answers.size() == 0) begin
            stray_answers++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("%0t: answer with none owed: ok=%0b count=%0d",
                        $time, got.ok, got.count);
            end
            return;
         end
         want = pending_answers.pop_front();
         answers_checked++;
         if (got.ok !== want.ok || got.count !== want.count) begin
            mismatches++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("%0t: answer mismatch: expected ok=%0b count=%0d, got ok=%0b count=%0d",
                        $time, want.ok, want.count, got.ok, got.count);
            end
         end
      endfunction

      function int fill();
         return stored.size();
      endfunction

      // Any value now in the list, so that searches can hit
      function logic signed [31:0] pick_stored();
         return stored[$urandom_range(0, stored.size() - 1)];
      endfunction

      function int owed();
         return pending_answers.size();
      endfunction

      function int failures();
         return mismatches + stray_answers + pending_answers.size();
      endfunction
   endclass

endpackage

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Top-level bench for positional_list_engine: drives commands over the
// start/busy port, checks every strobed answer against list_tracker.
// Depends on ple_pkg, list_tracker_pkg and the engine RTL.
module testbench;
   import ple_pkg::*;
   import list_tracker_pkg::*;

   localparam logic [2:0] CMD_UNUSED    = 3'd7;
   localparam int         SEGMENTS      = 20;
   localparam int         SEGMENT_ITEMS = 100;
   localparam int         SETTLE_CYCLES = 3 * LIST_DEPTH + 16;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   list_tracker tracker;
   int          items_sent;
   int          directed_items;

   positional_list_engine #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Check each strobed answer as the edge that ends its cycle takes it
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1)
         tracker.check_answer(rsp_item);
   end

   // Offer one item and hold it until an edge with busy low takes it
   task automatic send_command(input req_type item);
      req_item <= item;
      start    <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      tracker.note_command(item);
      items_sent++;
   endtask

   // Drop start for a while; scramble the item lines meanwhile
   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         start    <= 1'b0;
         req_item <= req_type'({$urandom, $urandom});
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Mostly no gap or a short one, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic req_type make_item(logic [2:0] cmd, logic [6:0] pos,
                                         logic signed [31:0] v);
      req_type item;
      item.cmd      = cmd;
      item.position = pos;
      item.value    = v;
      return item;
   endfunction

   // Small values collide often, extremes stress the compare
   function automatic logic signed [31:0] random_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            v = $urandom_range(0, 7);
            v = v - 4;
         end
         3:       v = 32'sh8000_0000;
         4:       v = 32'sh7FFF_FFFF;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Mostly well-formed commands for the current fill; some noise
   function automatic req_type random_command(input int insert_share);
      req_type item;
      int      n;
      int      r;
      n             = tracker.fill();
      r             = $urandom_range(0, 99);
      item.cmd      = CMD_SEARCH;
      item.value    = random_value();
      item.position = 7'($urandom);
      if (r < insert_share) begin
         case ($urandom_range(0, 2))
            0:       item.cmd = CMD_PUSH_FRONT;
            1:       item.cmd = CMD_PUSH_BACK;
            default: item.cmd = CMD_INSERT_AT;
         endcase
         if ($urandom_range(0, 9) != 0)
            item.position = 7'($urandom_range(0, n));
      end else if (r < 92) begin
         case ($urandom_range(0, 9))
            0, 1:    item.cmd = CMD_POP_FRONT;
            2, 3:    item.cmd = CMD_POP_BACK;
            4, 5, 6: item.cmd = CMD_REMOVE_AT;
            default: item.cmd = CMD_SEARCH;
         endcase
         if (n > 0 && $urandom_range(0, 9) != 0)
            item.position = 7'($urandom_range(0, n - 1));
         if (item.cmd == CMD_SEARCH && n > 0 && $urandom_range(0, 2) != 0)
            item.value = tracker.pick_stored();
      end else begin
         item.cmd = 3'($urandom);
      end
      return item;
   endfunction

   initial begin
      req_type directed[$];
      int      insert_share;
      bit      no_gaps;
      tracker = new();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, list ends, middle, bad positions, unused code
      directed.push_back(make_item(CMD_POP_FRONT, 7'd0, 32'sd0));
      directed.push_back(make_item(CMD_POP_BACK, 7'd0, 32'sd0));
      directed.push_back(make_item(CMD_REMOVE_AT, 7'd0, 32'sd0));
      directed.push_back(make_item(CMD_SEARCH, 7'd0, 32'sd0));
      directed.push_back(make_item(CMD_UNUSED, 7'd0, 32'sd0));
      directed.push_back(make_item(CMD_INSERT_AT, 7'd1, 32'sd9));
      directed.push_back(make_item(CMD_INSERT_AT, 7'd0, 32'sd5));
      directed.push_back(make_item(CMD_PUSH_FRONT, 7'd0, 32'sh8000_0000));
      directed.push_back(make_item(CMD_PUSH_BACK, 7'd0, 32'sh7FFF_FFFF));
      directed.push_back(make_item(CMD_INSERT_AT, 7'd3, -32'sd1));
      directed.push_back(make_item(CMD_INSERT_AT, 7'd2, 32'sd0));
      directed.push_back(make_item(CMD_INSERT_AT, 7'd127, 32'sd7));
      directed.push_back(make_item(CMD_INSERT_AT, 7'd6, 32'sd7));
      directed.push_back(make_item(CMD_SEARCH, 7'd0, 32'sh7FFF_FFFF));
      directed.push_back(make_item(CMD_SEARCH, 7'd0, 32'sh8000_0000));
      directed.push_back(make_item(CMD_SEARCH, 7'd0, 32'sd12345));
      directed.push_back(make_item(CMD_REMOVE_AT, 7'd5, 32'sd0));
      directed.push_back(make_item(CMD_REMOVE_AT, 7'd127, 32'sd0));
      directed.push_back(make_item(CMD_REMOVE_AT, 7'd2, 32'sd0));
      directed.push_back(make_item(CMD_POP_FRONT, 7'd0, 32'sd0));
      directed.push_back(make_item(CMD_POP_BACK, 7'd0, 32'sd0));
      directed.push_back(make_item(CMD_REMOVE_AT, 7'd1, 32'sd0));
      directed.push_back(make_item(CMD_REMOVE_AT, 7'd0, 32'sd0));
      directed.push_back(make_item(CMD_SEARCH, 7'd0, 32'sd5));
      directed.push_back(make_item(CMD_UNUSED, 7'h7F, -32'sd1));
      foreach (directed[i])
         send_command(directed[i]);
      directed_items = items_sent;

      // Random: segments that fill, drain or churn the list
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0:       insert_share = 80;
            2:       insert_share = 20;
            default: insert_share = 48;
         endcase
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < SEGMENT_ITEMS; k++) begin
            send_command(random_command(insert_share));
            if (!no_gaps)
               idle_sender(gap_length());
         end
      end

      // Drain: wait for every owed answer, then watch for strays
      start <= 1'b0;
      while (tracker.owed() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d commands (%0d directed), checked %0d answers, %0d search hits.",
               items_sent, directed_items, tracker.answers_checked, tracker.search_hits);
      $display("Peak fill %0d of %0d, %0d inserts refused on a full list, %0d failures.",
               tracker.peak_fill, LIST_DEPTH, tracker.full_refusals, tracker.failures());
      if (tracker.failures() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard stop far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("Timeout with %0d answers still owed", tracker.owed());
      $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/ple_pkg.sv
hw/rtl/ple_store.sv
hw/rtl/ple_datapath.sv
hw/rtl/ple_sequencer.sv
hw/rtl/positional_list_engine.sv
hw/rtl/ple_checker.sv
bench/list_tracker_pkg.sv
bench/testbench.sv
